/* rtl/prtb_pkg.sv */
// Package for the prescaled reload timer bank: beat payload types,
// command and register offset codes, and the period and shift helpers.
// No dependencies.
package prtb_pkg;

   // Timers in the bank; the result mask shows only the first three.
   localparam int TIMER_COUNT = 3;
   localparam int EXPIRE_W    = 3;
   localparam int MASK_ALL_W  = (TIMER_COUNT > EXPIRE_W) ? TIMER_COUNT : EXPIRE_W;

   localparam int CMD_W  = 2;
   localparam int SEL_W  = 2;
   localparam int OFS_W  = 8;
   localparam int WORD_W = 32;
   localparam int CTRL_W = 6;
   localparam int CNT_W  = 41;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

   localparam logic [OFS_W-1:0] OFS_CONTROL = 8'h00;
   localparam logic [OFS_W-1:0] OFS_LOAD    = 8'h04;
   localparam logic [OFS_W-1:0] OFS_COUNTER = 8'h08;

   localparam int CTRL_RUN    = 0;
   localparam int CTRL_RELOAD = 1;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SEL_W-1:0]  timer_select;
      logic [OFS_W-1:0]  reg_offset;
      logic [WORD_W-1:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_data;
      logic [EXPIRE_W-1:0] expired_mask;
      logic                access_error;
   } rsp_payload_type;

   // Prescale p divides by 2^(p+1).
   function automatic logic [3:0] shift_of(input logic [CTRL_W-1:0] ctrl);
      return 4'd1 + {1'b0, ctrl[4:2]};
   endfunction

   // Remaining-tick count for a full period: (load+1) << (p+1), kept to 41 bits.
   function automatic logic [CNT_W-1:0] period_of(input logic [WORD_W-1:0] load,
                                                   input logic [CTRL_W-1:0] ctrl);
      logic [CNT_W-1:0] n;
      n = {{(CNT_W-WORD_W){1'b0}}, load} + {{(CNT_W-1){1'b0}}, 1'b1};
      return n << shift_of(ctrl);
   endfunction

endpackage

/* rtl/prescaled_reload_timer_bank_top.sv */
// Top level of the prescaled reload timer bank: timer state, register access
// and a two-beat result buffer (output register plus skid stage).
// Depends on prtb_pkg.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   req     | in  | req_valid/stall    | command, timer_select, offset, data
//   rsp     | out | rsp_valid/stall    | read_data, expired_mask, access_error
//
// One beat per cycle while req_stall is low: each accepted beat updates the timer
// registers in the cycle it is taken, and its result is registered into the output
// register, or into the skid stage while a stalled result holds the output register.
// Reset (synchronous, active high) stops all timers, clears the counts, sets
// every load register to all ones and empties the result buffer.
// A stalled result holds in the output register; one more beat lands in the
// skid stage, and req_stall rises while the skid stage is full.
module prescaled_reload_timer_bank_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  prtb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output prtb_pkg::rsp_payload_type rsp_payload
);

   // Timer state
   logic [prtb_pkg::CTRL_W-1:0] ctrl_ff [prtb_pkg::TIMER_COUNT];
   logic [prtb_pkg::CTRL_W-1:0] ctrl_in [prtb_pkg::TIMER_COUNT];
   logic [prtb_pkg::WORD_W-1:0] load_ff [prtb_pkg::TIMER_COUNT];
   logic [prtb_pkg::WORD_W-1:0] load_in [prtb_pkg::TIMER_COUNT];
   logic [prtb_pkg::CNT_W-1:0]  cnt_ff  [prtb_pkg::TIMER_COUNT];
   logic [prtb_pkg::CNT_W-1:0]  cnt_in  [prtb_pkg::TIMER_COUNT];

   // Result buffer
   logic                      out_valid_ff, out_valid_in;
   prtb_pkg::rsp_payload_type out_data_ff,  out_data_in;
   logic                      skid_valid_ff, skid_valid_in;
   prtb_pkg::rsp_payload_type skid_data_ff,  skid_data_in;

   logic                      req_take;
   logic                      rsp_take;
   logic                      sel_ok;
   logic [prtb_pkg::MASK_ALL_W-1:0] mask_all;
   prtb_pkg::rsp_payload_type result;

   // Stall the request side only while the skid stage holds a beat.
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;

   assign sel_ok = (int'(req_payload.timer_select) < prtb_pkg::TIMER_COUNT);

   // Work out the result of the incoming beat and the next timer state.
   always_comb begin
      mask_all = '0;
      result   = '0;
      for (int t = 0; t < prtb_pkg::TIMER_COUNT; t++) begin
         ctrl_in[t] = ctrl_ff[t];
         load_in[t] = load_ff[t];
         cnt_in[t]  = cnt_ff[t];
      end

      if (req_take) begin
         case (req_payload.command)
            prtb_pkg::CMD_TICK: begin
               // Advance every running timer; expire at one (or a stray zero).
               for (int t = 0; t < prtb_pkg::TIMER_COUNT; t++) begin
                  if (ctrl_ff[t][prtb_pkg::CTRL_RUN]) begin
                     if (cnt_ff[t] <= {{(prtb_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
                        mask_all[t] = 1'b1;
                        if (ctrl_ff[t][prtb_pkg::CTRL_RELOAD]) begin
                           cnt_in[t] = prtb_pkg::period_of(load_ff[t], ctrl_ff[t]);
                        end else begin
                           ctrl_in[t][prtb_pkg::CTRL_RUN] = 1'b0;
                           cnt_in[t] = '0;
                        end
                     end else begin
                        cnt_in[t] = cnt_ff[t] - {{(prtb_pkg::CNT_W-1){1'b0}}, 1'b1};
                     end
                  end
               end
            end
            prtb_pkg::CMD_READ: begin
               if (!sel_ok) begin
                  result.access_error = 1'b1;
               end
               for (int t = 0; t < prtb_pkg::TIMER_COUNT; t++) begin
                  if (req_payload.timer_select == prtb_pkg::SEL_W'(t)) begin
                     case (req_payload.reg_offset)
                        prtb_pkg::OFS_CONTROL: begin
                           result.read_data = {{(prtb_pkg::WORD_W-prtb_pkg::CTRL_W){1'b0}},
                                               ctrl_ff[t]};
                        end
                        prtb_pkg::OFS_COUNTER: begin
                           // A running count is in input ticks; scale it down.
                           if (ctrl_ff[t][prtb_pkg::CTRL_RUN]) begin
                              result.read_data = prtb_pkg::WORD_W'(
                                 cnt_ff[t] >> prtb_pkg::shift_of(ctrl_ff[t]));
                           end else begin
                              result.read_data = cnt_ff[t][prtb_pkg::WORD_W-1:0];
                           end
                        end
                        default: begin
                           result.access_error = 1'b1;
                        end
                     endcase
                  end
               end
            end
            prtb_pkg::CMD_WRITE: begin
               if (!sel_ok) begin
                  result.access_error = 1'b1;
               end
               for (int t = 0; t < prtb_pkg::TIMER_COUNT; t++) begin
                  if (req_payload.timer_select == prtb_pkg::SEL_W'(t)) begin
                     case (req_payload.reg_offset)
                        prtb_pkg::OFS_CONTROL: begin
                           ctrl_in[t] = req_payload.write_data[prtb_pkg::CTRL_W-1:0];
                           if (ctrl_in[t][prtb_pkg::CTRL_RUN] !=
                               ctrl_ff[t][prtb_pkg::CTRL_RUN]) begin
                              if (ctrl_in[t][prtb_pkg::CTRL_RUN]) begin
                                 // Start: load a full period.
                                 cnt_in[t] = prtb_pkg::period_of(load_ff[t], ctrl_in[t]);
                              end else begin
                                 // Stop: freeze the scaled count.
                                 cnt_in[t] = cnt_ff[t] >> prtb_pkg::shift_of(ctrl_in[t]);
                              end
                           end
                        end
                        prtb_pkg::OFS_LOAD: begin
                           load_in[t] = req_payload.write_data;
                        end
                        default: begin
                           result.access_error = 1'b1;
                        end
                     endcase
                  end
               end
            end
            default: begin
               result = '0;
            end
         endcase
      end

      result.expired_mask = mask_all[prtb_pkg::EXPIRE_W-1:0];
   end

   // Route results through the output register and the skid stage.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int t = 0; t < prtb_pkg::TIMER_COUNT; t++) begin
            ctrl_ff[t] <= '0;
            load_ff[t] <= '1;
            cnt_ff[t]  <= '0;
         end
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int t = 0; t < prtb_pkg::TIMER_COUNT; t++) begin
            ctrl_ff[t] <= ctrl_in[t];
            load_ff[t] <= load_in[t];
            cnt_ff[t]  <= cnt_in[t];
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* tb/sv/prtb_timer_checker.sv */
// Result checker for the prescaled reload timer bank: mirrors the timer state,
// predicts one result per request beat and compares result beats in order.
// Depends on prtb_pkg.
module prtb_timer_checker
   import prtb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              mismatches,
   output int              outstanding
);

   logic [CTRL_W-1:0] ctrl_bits  [TIMER_COUNT];
   logic [WORD_W-1:0] load_word  [TIMER_COUNT];
   logic [CNT_W-1:0]  ticks_left [TIMER_COUNT];

   rsp_payload_type timer_rsp_q [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Input ticks per visible count: 2^(p+1).
   function automatic int unsigned divider_log2(input logic [CTRL_W-1:0] ctrl);
      return int'(ctrl[4:2]) + 1;
   endfunction

   function automatic logic [CNT_W-1:0] full_ticks(input logic [WORD_W-1:0] load,
                                                   input logic [CTRL_W-1:0] ctrl);
      logic [CNT_W-1:0] n;
      n = '0;
      n[WORD_W-1:0] = load;
      n = n + 1'b1;
      return n << divider_log2(ctrl);
   endfunction

   // Apply one beat to the mirrored bank and return the result it causes.
   function automatic rsp_payload_type apply_timer_access(input req_payload_type beat);
      rsp_payload_type  r;
      logic [CTRL_W-1:0] nv;
      logic [CNT_W-1:0]  scaled;
      int unsigned       t;
      r = '0;
      case (beat.command)
         CMD_TICK: begin
            for (t = 0; t < TIMER_COUNT; t++) begin
               if (ctrl_bits[t][CTRL_RUN]) begin
                  if (ticks_left[t] <= 1) begin
                     if (t < EXPIRE_W) r.expired_mask[t] = 1'b1;
                     if (ctrl_bits[t][CTRL_RELOAD]) begin
                        ticks_left[t] = full_ticks(load_word[t], ctrl_bits[t]);
                     end else begin
                        ctrl_bits[t][CTRL_RUN] = 1'b0;
                        ticks_left[t] = '0;
                     end
                  end else begin
                     ticks_left[t] = ticks_left[t] - 1'b1;
                  end
               end
            end
         end
         CMD_READ, CMD_WRITE: begin
            if (beat.timer_select >= TIMER_COUNT) begin
               r.access_error = 1'b1;
            end else begin
               t = 32'(beat.timer_select);
               if (beat.command == CMD_READ) begin
                  case (beat.reg_offset)
                     OFS_CONTROL: r.read_data = WORD_W'(ctrl_bits[t]);
                     OFS_COUNTER: begin
                        if (ctrl_bits[t][CTRL_RUN]) begin
                           scaled = ticks_left[t] >> divider_log2(ctrl_bits[t]);
                           r.read_data = scaled[WORD_W-1:0];
                        end else begin
                           r.read_data = ticks_left[t][WORD_W-1:0];
                        end
                     end
                     default: r.access_error = 1'b1;
                  endcase
               end else begin
                  case (beat.reg_offset)
                     OFS_CONTROL: begin
                        nv = beat.write_data[CTRL_W-1:0];
                        if (nv[CTRL_RUN] != ctrl_bits[t][CTRL_RUN]) begin
                           if (nv[CTRL_RUN]) ticks_left[t] = full_ticks(load_word[t], nv);
                           else ticks_left[t] = ticks_left[t] >> divider_log2(nv);
                        end
                        ctrl_bits[t] = nv;
                     end
                     OFS_LOAD: load_word[t] = beat.write_data;
                     default: r.access_error = 1'b1;
                  endcase
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      if (mismatches < 10) $display("%m: %s", msg);
      mismatches++;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int t = 0; t < TIMER_COUNT; t++) begin
            ctrl_bits[t]  = '0;
            load_word[t]  = '1;
            ticks_left[t] = '0;
         end
         timer_rsp_q.delete();
      end else begin
         // A result is registered, so compare before queuing this edge's beat.
         if (rsp_valid && !rsp_stall) begin
            if (timer_rsp_q.size() == 0) begin
               note_failure($sformatf("result beat with none pending: data %h mask %b err %b",
                                      rsp_payload.read_data, rsp_payload.expired_mask,
                                      rsp_payload.access_error));
            end else begin
               want = timer_rsp_q.pop_front();
               if (want.read_data !== rsp_payload.read_data ||
                   want.expired_mask !== rsp_payload.expired_mask ||
                   want.access_error !== rsp_payload.access_error) begin
                  note_failure($sformatf(
                     "expected data %h mask %b err %b, got data %h mask %b err %b",
                     want.read_data, want.expired_mask, want.access_error,
                     rsp_payload.read_data, rsp_payload.expired_mask,
                     rsp_payload.access_error));
               end
            end
         end
         if (req_valid && !req_stall) timer_rsp_q.push_back(apply_timer_access(req_payload));
      end
      outstanding <= timer_rsp_q.size();
   end

endmodule

/* tb/sv/prescaled_reload_timer_bank_top_test.sv */
// Testbench top for the prescaled reload timer bank: clock, reset, request
// stimulus, result-side stalls, watchdog and verdict.
// Depends on prtb_pkg, prescaled_reload_timer_bank_top and prtb_timer_checker.
module prescaled_reload_timer_bank_top_test;
   import prtb_pkg::*;

   // The block ignores this command value; it still returns an all-zero beat.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // Cycles with no beat moved on either channel before the run is abandoned.
   localparam int STALL_LIMIT  = 1000;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_BEATS  = 150;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int   bank_failures;
   int   bank_outstanding;
   int   idle_cycles = 0;
   int   rsp_hold = 0;
   logic rsp_taken = 1'b0;
   bit   quiet_phase = 1'b0;

   always #2 clock = ~clock;

   prescaled_reload_timer_bank_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   prtb_timer_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mismatches  (bank_failures),
      .outstanding (bank_outstanding)
   );

   // Wait before a beat: none in quiet phases, otherwise often none and
   // otherwise a randomly drawn wait.
   function automatic int draw_wait();
      if (quiet_phase) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic req_payload_type make_beat(input logic [CMD_W-1:0]  cmd,
                                                 input logic [SEL_W-1:0]  sel,
                                                 input logic [OFS_W-1:0]  ofs,
                                                 input logic [WORD_W-1:0] data);
      req_payload_type b;
      b.command      = cmd;
      b.timer_select = sel;
      b.reg_offset   = ofs;
      b.write_data   = data;
      return b;
   endfunction

   // Control word: run, auto-reload, prescale, plus the unused bit 5 and
   // whatever upper bits the caller wants to see dropped.
   function automatic logic [WORD_W-1:0] ctrl_word(input bit run, input bit reload,
                                                   input logic [2:0] prescale,
                                                   input logic [WORD_W-1:0] upper);
      logic [WORD_W-1:0] w;
      w = upper;
      w[CTRL_RUN]    = run;
      w[CTRL_RELOAD] = reload;
      w[4:2]         = prescale;
      return w;
   endfunction

   // Random beat: mostly ticks so that programmed timers run down, with
   // small loads and prescales so expiry and reload happen often.
   function automatic req_payload_type make_random_beat();
      req_payload_type b;
      int              roll;
      logic [2:0]      prescale;
      roll = $urandom_range(0, 99);
      if (roll < 55) b.command = CMD_TICK;
      else if (roll < 75) b.command = CMD_READ;
      else if (roll < 97) b.command = CMD_WRITE;
      else b.command = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) b.timer_select = '1;
      else b.timer_select = SEL_W'($urandom_range(0, TIMER_COUNT - 1));
      roll = $urandom_range(0, 99);
      if (roll < 30) b.reg_offset = OFS_CONTROL;
      else if (roll < 60) b.reg_offset = OFS_LOAD;
      else if (roll < 85) b.reg_offset = OFS_COUNTER;
      else b.reg_offset = OFS_W'($urandom_range(0, 255));
      b.write_data = $urandom();
      if (b.reg_offset == OFS_CONTROL) begin
         prescale = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1)) : 3'($urandom);
         b.write_data = ctrl_word($urandom_range(0, 9) < 7, 1'($urandom), prescale,
                                  b.write_data);
      end else if (b.reg_offset == OFS_LOAD && $urandom_range(0, 99) < 65) begin
         b.write_data = WORD_W'($urandom_range(0, 6));
      end
      return b;
   endfunction

   // Hold valid low for a drawn gap, then present the beat and hold it until
   // it is taken. Valid stays high into the next call when that gap is zero.
   task automatic send_beat(input req_payload_type beat);
      int gap;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every predicted result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bank_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Result side: after each result beat, draw how long to stall the next one.
   always @(posedge clock) rsp_taken <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (rsp_taken) rsp_hold = draw_wait();
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("prescaled_reload_timer_bank_top_test: done, errors");
      $finish;
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset values, every access error and the ignored command.
      send_beat(make_beat(CMD_READ, 2'd0, OFS_CONTROL, '0));
      send_beat(make_beat(CMD_READ, 2'd0, OFS_COUNTER, '0));
      send_beat(make_beat(CMD_READ, 2'd0, OFS_LOAD, '0));
      send_beat(make_beat(CMD_WRITE, 2'd1, OFS_COUNTER, '1));
      send_beat(make_beat(CMD_READ, 2'd2, '1, '0));
      send_beat(make_beat(CMD_READ, '1, OFS_CONTROL, '0));
      send_beat(make_beat(CMD_WRITE, '1, OFS_LOAD, '1));
      send_beat(make_beat(CMD_UNUSED, '1, '1, '1));
      send_beat(make_beat(CMD_TICK, '0, '0, '0));

      // Shortest auto-reload period: load 0, prescale 0 gives two ticks.
      send_beat(make_beat(CMD_WRITE, 2'd0, OFS_LOAD, '0));
      send_beat(make_beat(CMD_WRITE, 2'd0, OFS_CONTROL,
                          ctrl_word(1'b1, 1'b1, 3'd0, '0)));
      send_beat(make_beat(CMD_TICK, '0, '0, '0));
      send_beat(make_beat(CMD_TICK, '0, '0, '0));
      send_beat(make_beat(CMD_READ, 2'd0, OFS_COUNTER, '0));

      // One-shot at the largest prescale, then stop it and read the frozen count.
      send_beat(make_beat(CMD_WRITE, 2'd1, OFS_LOAD, 32'd1));
      send_beat(make_beat(CMD_WRITE, 2'd1, OFS_CONTROL,
                          ctrl_word(1'b1, 1'b0, 3'd7, '0)));
      send_beat(make_beat(CMD_READ, 2'd1, OFS_COUNTER, '0));
      send_beat(make_beat(CMD_WRITE, 2'd1, OFS_CONTROL,
                          ctrl_word(1'b0, 1'b0, 3'd7, '0)));
      send_beat(make_beat(CMD_READ, 2'd1, OFS_COUNTER, '0));

      // Largest period: the counter read wraps past 32 bits.
      send_beat(make_beat(CMD_WRITE, 2'd2, OFS_LOAD, '1));
      send_beat(make_beat(CMD_WRITE, 2'd2, OFS_CONTROL, '1));
      send_beat(make_beat(CMD_READ, 2'd2, OFS_COUNTER, '0));
      send_beat(make_beat(CMD_READ, 2'd2, OFS_CONTROL, '0));

      // Upper write bits are dropped; this stops timer 0.
      send_beat(make_beat(CMD_WRITE, 2'd0, OFS_CONTROL,
                          ctrl_word(1'b0, 1'b0, 3'd0, '1)));
      send_beat(make_beat(CMD_TICK, '0, '0, '0));
      drain_results();

      // Random phases; some run back to back on both sides, each ends drained.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         quiet_phase = (ph == 1 || ph == 4);
         for (int n = 0; n < PHASE_BEATS; n++) send_beat(make_random_beat());
         drain_results();
      end

      if (bank_failures == 0 && bank_outstanding == 0) begin
         $display("prescaled_reload_timer_bank_top_test: done, clean");
      end else begin
         $display("prescaled_reload_timer_bank_top_test: done, errors");
      end
      $finish;
   end

endmodule

/* prescaled_reload_timer_bank_top.f */
rtl/prtb_pkg.sv
rtl/prescaled_reload_timer_bank_top.sv
tb/sv/prtb_timer_checker.sv
tb/sv/prescaled_reload_timer_bank_top_test.sv
